/* rtl/core/bbc_pkg.sv */
// shared types and constants of the biquad band-pass cascade core
// used by biquad_bandpass_cascade_core; depends on nothing
package bbc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int FRAC_BITS = 21;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    // five products of PROD_W bits each get four more bits of headroom
    localparam int ACC_W     = PROD_W + 4;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd2097152;

    // per-stage sequencer steps
    localparam logic [STEP_W-1:0] STEP_B0    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_B1    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_B2    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_A1    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_A2    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SUM   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ROUND = 3'd6;

    // history slots inside one stage's group of four entries
    localparam logic [1:0] SLOT_X1 = 2'd0;
    localparam logic [1:0] SLOT_X2 = 2'd1;
    localparam logic [1:0] SLOT_Y1 = 2'd2;
    localparam logic [1:0] SLOT_Y2 = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       frame_end;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_end_out;
    } result_t;

endpackage

/* rtl/core/bbc_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// standalone, no package needed
module bbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/biquad_bandpass_cascade_core.sv */
// cascade of direct-form-1 biquad stages sharing one multiplier and one history ram
// depends on bbc_pkg and bbc_ram
//
// usage
//   item channel: item_valid / item_stall / item carry one raw sample and its
//   frame end mark. result channel: result_valid / result_stall / result carry
//   the filtered sample after all stages and the copied mark.
//   cfg_we / cfg_index / cfg_data write the five shared Q2.21 taps; the user must
//   write them only while the core is idle, the core does not enforce it; indexes above four are ignored.
// sequencing
//   each stage runs on the single 24x16 multiplier in steps: five products,
//   one closing add, one round and saturate step. the result is registered
//   from the output state once the output register is free, and a new item
//   is taken only after the core is idle again, so one sample is in flight at
//   a time. item_stall is high while a sample is in flight.
// reset and stall
//   reset clears the taps to a pass-through filter and marks all history
//   entries as zero through per-entry valid bits, no clearing pass. a stalled
//   result holds in its output register; the core still takes and works the
//   next item and waits with that one finished until the register frees.
module biquad_bandpass_cascade_core #(
    parameter int STAGE_COUNT = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  bbc_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output bbc_pkg::result_t                      result,
    input  logic                                  cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bbc_pkg::COEF_W-1:0]            cfg_data
);

    import bbc_pkg::*;

    localparam int DEPTH   = 4 * STAGE_COUNT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int RND_W   = ACC_W - FRAC_BITS;
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);
    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] RND_MIN = -RND_W'(32768);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [STAGE_W-1:0]           stage_reg, stage_next;
    logic signed [SAMPLE_W-1:0]   x_reg, x_next;
    logic                         mark_reg, mark_next;
    logic signed [SAMPLE_W-1:0]   x1_save_reg, x1_save_next;
    logic signed [SAMPLE_W-1:0]   y1_save_reg, y1_save_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic                         rvalid_reg, rvalid_next;
    logic [DEPTH-1:0]             valid_reg, valid_next;
    logic                         result_valid_reg, result_valid_next;
    result_t                      result_reg, result_next;

    logic signed [COEF_W-1:0]     b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [SAMPLE_W-1:0]          ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [SAMPLE_W-1:0]          ram_rdata;

    logic signed [SAMPLE_W-1:0]   hist_val;
    logic signed [COEF_W-1:0]     mult_a;
    logic signed [SAMPLE_W-1:0]   mult_b;
    logic signed [ACC_W-1:0]      acc_biased;
    logic signed [RND_W-1:0]      rnd;
    logic signed [SAMPLE_W-1:0]   y_sat;
    logic                         item_beat;
    logic                         out_free;

    bbc_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_hist_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign item_beat    = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // never-written history entries read as zero
    assign hist_val = rvalid_reg ? $signed(ram_rdata) : '0;

    assign acc_biased = acc_reg + HALF_LSB;
    assign rnd        = acc_biased[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        priority if (rnd > RND_MAX)
        begin
            y_sat = SAMPLE_W'(RND_MAX);
        end
        else if (rnd < RND_MIN)
        begin
            y_sat = SAMPLE_W'(RND_MIN);
        end
        else
        begin
            y_sat = rnd[SAMPLE_W-1:0];
        end
    end

    // tap and operand selection for the shared multiplier
    always_comb
    begin
        mult_b = hist_val;
        unique case (step_reg)
            STEP_B0:
            begin
                mult_a = b0_reg;
                mult_b = x_reg;
            end
            STEP_B1: mult_a = b1_reg;
            STEP_B2: mult_a = b2_reg;
            STEP_A1: mult_a = a1_reg;
            STEP_A2: mult_a = a2_reg;
            default: mult_a = '0;
        endcase
    end

    assign prod_next = PROD_W'(mult_a) * PROD_W'(mult_b);

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        stage_next        = stage_reg;
        x_next            = x_reg;
        mark_next         = mark_reg;
        x1_save_next      = x1_save_reg;
        y1_save_next      = y1_save_reg;
        acc_next          = acc_reg;
        valid_next        = valid_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = ADDR_W'({stage_reg, SLOT_X1});
        ram_wdata         = x_reg;
        ram_raddr         = ADDR_W'({stage_reg, step_reg[1:0]});

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_beat)
                begin
                    x_next     = item.sample_in;
                    mark_next  = item.frame_end;
                    stage_next = '0;
                    step_next  = STEP_B0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                step_next = step_reg + STEP_W'(1);
                // reads of slots 0..3 go out in steps 0..3; each slot is
                // rewritten only after its own read has been issued
                unique case (step_reg)
                    STEP_B0:
                    begin
                    end
                    STEP_B1:
                    begin
                        acc_next     = ACC_W'(prod_reg);
                        x1_save_next = hist_val;
                        ram_we       = 1'b1;
                        ram_waddr    = ADDR_W'({stage_reg, SLOT_X1});
                        ram_wdata    = x_reg;
                    end
                    STEP_B2:
                    begin
                        acc_next  = acc_reg + ACC_W'(prod_reg);
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'({stage_reg, SLOT_X2});
                        ram_wdata = x1_save_reg;
                    end
                    STEP_A1:
                    begin
                        acc_next     = acc_reg + ACC_W'(prod_reg);
                        y1_save_next = hist_val;
                    end
                    STEP_A2:
                    begin
                        acc_next  = acc_reg + ACC_W'(prod_reg);
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'({stage_reg, SLOT_Y2});
                        ram_wdata = y1_save_reg;
                    end
                    STEP_SUM:
                    begin
                        acc_next = acc_reg + ACC_W'(prod_reg);
                    end
                    STEP_ROUND:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'({stage_reg, SLOT_Y1});
                        ram_wdata = y_sat;
                        x_next    = y_sat;
                        step_next = STEP_B0;
                        if (stage_reg == LAST_STAGE)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            stage_next = stage_reg + STAGE_W'(1);
                        end
                    end
                    default:
                    begin
                        step_next = STEP_B0;
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next           = 1'b1;
                    result_next.sample_out      = x_reg;
                    result_next.frame_end_out   = mark_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    assign rvalid_next = valid_reg[ram_raddr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= STEP_B0;
            stage_reg        <= '0;
            valid_reg        <= '0;
            rvalid_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            b0_reg           <= B0_RESET;
            b1_reg           <= '0;
            b2_reg           <= '0;
            a1_reg           <= '0;
            a2_reg           <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            stage_reg        <= stage_next;
            valid_reg        <= valid_next;
            rvalid_reg       <= rvalid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_B0:  b0_reg <= cfg_data;
                    CFG_B1:  b1_reg <= cfg_data;
                    CFG_B2:  b2_reg <= cfg_data;
                    CFG_A1:  a1_reg <= cfg_data;
                    CFG_A2:  a2_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        mark_reg    <= mark_next;
        x1_save_reg <= x1_save_next;
        y1_save_reg <= y1_save_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
    end

endmodule

/* verif/biquad_bandpass_cascade_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the biquad band-pass cascade core
// depends on bbc_pkg and biquad_bandpass_cascade_core; a small scoreboard class predicts every beat

class cascade_scoreboard;
    int                 taps [5];
    int                 hist [];
    int                 stages;
    int                 errors;
    bbc_pkg::result_t   filtered_due [$];

    function new(int n_stages);
        stages = n_stages;
        hist   = new[4 * n_stages];
        foreach (hist[i])
        begin
            hist[i] = 0;
        end
        taps[0] = int'(bbc_pkg::B0_RESET);
        taps[1] = 0;
        taps[2] = 0;
        taps[3] = 0;
        taps[4] = 0;
        errors  = 0;
    endfunction

    function void write_tap(logic [bbc_pkg::CFG_IDX_W-1:0] idx, logic [bbc_pkg::COEF_W-1:0] data);
        case (idx)
            bbc_pkg::CFG_B0: taps[0] = $signed(data);
            bbc_pkg::CFG_B1: taps[1] = $signed(data);
            bbc_pkg::CFG_B2: taps[2] = $signed(data);
            bbc_pkg::CFG_A1: taps[3] = $signed(data);
            bbc_pkg::CFG_A2: taps[4] = $signed(data);
            default: ;
        endcase
    endfunction

    // runs one accepted sample through every stage and queues the filtered output
    function void note_sample(bbc_pkg::item_t it);
        bbc_pkg::result_t want;
        int               x;
        int               base;
        longint           acc;
        longint           q;
        x = $signed(it.sample_in);
        for (int s = 0; s < stages; s++)
        begin
            base = 4 * s;
            acc = longint'(taps[0]) * x
                + longint'(taps[1]) * hist[base + bbc_pkg::SLOT_X1]
                + longint'(taps[2]) * hist[base + bbc_pkg::SLOT_X2]
                + longint'(taps[3]) * hist[base + bbc_pkg::SLOT_Y1]
                + longint'(taps[4]) * hist[base + bbc_pkg::SLOT_Y2];
            // floor shift after half bias, so exact halves go up
            q = (acc + (longint'(1) << (bbc_pkg::FRAC_BITS - 1))) >>> bbc_pkg::FRAC_BITS;
            if (q > 32767)
            begin
                q = 32767;
            end
            else if (q < -32768)
            begin
                q = -32768;
            end
            hist[base + bbc_pkg::SLOT_X2] = hist[base + bbc_pkg::SLOT_X1];
            hist[base + bbc_pkg::SLOT_X1] = x;
            hist[base + bbc_pkg::SLOT_Y2] = hist[base + bbc_pkg::SLOT_Y1];
            hist[base + bbc_pkg::SLOT_Y1] = int'(q);
            x = int'(q);
        end
        want.sample_out    = 16'(x);
        want.frame_end_out = it.frame_end;
        filtered_due.push_back(want);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_output(bbc_pkg::result_t got);
        bbc_pkg::result_t want;
        if (filtered_due.size() == 0)
        begin
            report($sformatf("output beat %0d with nothing expected", got.sample_out));
        end
        else
        begin
            want = filtered_due.pop_front();
            if (got.sample_out !== want.sample_out)
            begin
                report($sformatf("sample_out got %0d expected %0d",
                                 got.sample_out, want.sample_out));
            end
            if (got.frame_end_out !== want.frame_end_out)
            begin
                report($sformatf("frame_end_out got %0b expected %0b",
                                 got.frame_end_out, want.frame_end_out));
            end
        end
    endtask

    function int pending();
        return filtered_due.size();
    endfunction
endclass

module biquad_bandpass_cascade_core_tb;
    import bbc_pkg::*;

    localparam int STAGES       = 3;
    localparam int SAMPLE_CYC   = 7 * STAGES + 2;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 80;
    localparam int HOLD_PHASE   = 3;
    localparam int PAUSE_PHASE  = 6;
    localparam logic [COEF_W-1:0] TAP_MAX  = 24'h7FFFFF;
    localparam logic [COEF_W-1:0] TAP_MIN  = 24'h800000;
    localparam logic [COEF_W-1:0] TAP_HALF = 24'd1048576;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [COEF_W-1:0]     cfg_data     = '0;

    cascade_scoreboard sb = new(STAGES);

    int  gap_pct     = 0;
    int  stall_pct   = 0;
    bit  hold_req    = 1'b0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    biquad_bandpass_cascade_core #(
        .STAGE_COUNT (STAGES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_output(result);
            end
            if (item_valid && !item_stall)
            begin
                sb.note_sample(item);
            end
            if (cfg_we)
            begin
                sb.write_tap(cfg_index, cfg_data);
            end
        end
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("biquad_bandpass_cascade_core test failed");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic item_t make_item(logic signed [SAMPLE_W-1:0] v, logic fe);
        item_t it;
        it.sample_in = v;
        it.frame_end = fe;
        return it;
    endfunction

    function automatic logic [COEF_W-1:0] corner_tap();
        case ($urandom_range(0, 3))
            0:       return TAP_MAX;
            1:       return TAP_MIN;
            2:       return '0;
            default: return COEF_W'(B0_RESET);
        endcase
    endfunction

    // leaves valid high when no gap follows, so back-to-back beats need no toggle
    task automatic send_sample(item_t it);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // waits on the clock first so the monitor has noted the last accepted beat
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // core must be idle here; a stray write to an unused index rides along
    task automatic load_taps(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                             logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                             logic [COEF_W-1:0] a2);
        repeat (2) @(posedge clk);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_A2 + CFG_IDX_W'($urandom_range(1, 3)), COEF_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                         dir_vals [8] = '{0, 32767, -32768, 1, -1, 21845, -21846, 256};
        int                         tie_vals [6] = '{1, -1, 3, -3, 32767, -32768};
        int                         sat_vals [6] = '{32767, -32768, 32767, 0, -1, 1};
        int                         r_q;
        int                         b0;
        int                         a1;
        int                         a2;
        logic signed [SAMPLE_W-1:0] v;
        logic                       fe;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through taps out of reset
        for (int i = 0; i < 8; i++)
        begin
            send_sample(make_item(16'(dir_vals[i]), i[0]));
        end
        drain_results();

        // half gain: odd inputs land on exact halves
        load_taps(TAP_HALF, '0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
        begin
            send_sample(make_item(16'(tie_vals[i]), i[0]));
        end
        drain_results();

        // extreme taps drive every stage into saturation
        load_taps(TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN, TAP_MAX);
        for (int i = 0; i < 6; i++)
        begin
            send_sample(make_item(16'(sat_vals[i]), ~i[0]));
        end
        drain_results();

        v = '0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    // stable band-pass: poles at radius r, zeros at dc and nyquist
                    r_q = $urandom_range(1048576, 2076180);
                    a2  = -int'((longint'(r_q) * r_q) >>> FRAC_BITS);
                    a1  = int'($urandom_range(0, 4 * r_q)) - 2 * r_q;
                    b0  = $urandom_range(0, 1048576);
                    load_taps(COEF_W'(b0), '0, COEF_W'(-b0), COEF_W'(a1), COEF_W'(a2));
                end
                2:
                begin
                    load_taps(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                              COEF_W'($urandom), COEF_W'($urandom));
                end
                default:
                begin
                    load_taps(corner_tap(), corner_tap(), corner_tap(),
                              corner_tap(), corner_tap());
                end
            endcase

            if (ph >= PHASES - 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = (ph % 3 == 1) ? 0 : $urandom_range(0, 3) * 15;
                stall_pct = (ph % 3 == 2) ? 0 : $urandom_range(0, 3) * 15;
            end
            if (ph == HOLD_PHASE)
            begin
                hold_cycles = $urandom_range(300, 500);
                hold_req    = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: v = 16'($urandom);
                    6, 7:             v = 16'(int'($urandom_range(0, 1023)) - 512);
                    8:                v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    default:          ;  // repeat last value as a step
                endcase
                fe = ($urandom_range(0, 15) == 0);
                send_sample(make_item(v, fe));
                if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (SAMPLE_CYC + 8) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d outputs never arrived", sb.pending()));
        end
        if (sb.errors == 0)
        begin
            $display("biquad_bandpass_cascade_core test passed");
        end
        else
        begin
            $display("biquad_bandpass_cascade_core test failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/biquad_bandpass_cascade_core.sv
verif/biquad_bandpass_cascade_core_tb.sv
